@@ hdl/lru_key_value_cache_defines.svh @@
// Assertion macros shared by the checker of the LRU key-value cache.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define LKVC_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("lkvc assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define LKVC_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("lkvc assertion failed");

`endif

@@ hdl/lkvc_pkg.sv @@
// Types and constants shared by the LRU key-value cache modules.
`default_nettype none

package lkvc_pkg;

    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;
    localparam int ENTRIES_DEF = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // One stored entry as it moves from cell to cell.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    // Read-out gathered along the chain.
    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] value;
    } rd_t;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic cmp_en;
        logic upd_en;
        logic move;
        logic any_hit;
    } ctl_t;

endpackage

`default_nettype wire

@@ hdl/lkvc_cell.sv @@
// One cell of the recency-ordered entry chain: holds one entry and its match flag.
`default_nettype none

module lkvc_cell #(
    parameter int IDX  = 0,
    parameter int IDXW = 4
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire lkvc_pkg::ctl_t           ctl,
    input  wire logic [lkvc_pkg::KEY_W-1:0] cmp_key,
    input  wire logic [IDXW-1:0]          tgt_index,
    input  wire lkvc_pkg::entry_t         prev_entry,
    output lkvc_pkg::entry_t              entry_out,
    input  wire logic                     sel_in,
    output logic                          sel_out,
    input  wire lkvc_pkg::rd_t            rd_in,
    output lkvc_pkg::rd_t                 rd_out
);

    logic                       valid_reg;
    logic [lkvc_pkg::KEY_W-1:0] key_reg;
    logic [lkvc_pkg::VAL_W-1:0] val_reg;
    logic                       hit_reg;
    logic                       my_tgt;
    logic                       shift;

    // On a hit the matching cell is the target; otherwise the slot picked by the top.
    assign my_tgt  = ctl.any_hit ? hit_reg : (tgt_index == IDXW'(IDX));
    assign sel_out = sel_in | my_tgt;
    assign shift   = ctl.move & sel_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.cmp_en)
            begin
                hit_reg <= valid_reg && (key_reg == cmp_key);
            end
            if (shift)
            begin
                valid_reg <= prev_entry.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg <= prev_entry.key;
            val_reg <= prev_entry.value;
        end
    end

    assign entry_out.valid = valid_reg;
    assign entry_out.key   = key_reg;
    assign entry_out.value = val_reg;

    assign rd_out.found = rd_in.found | hit_reg;
    assign rd_out.value = rd_in.value | (hit_reg ? val_reg : '0);

endmodule

`default_nettype wire

@@ hdl/lru_key_value_cache.sv @@
// Top level of the LRU key-value cache: request control, occupancy and the cell chain.
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement. Entries
// sit in a row of cells ordered by recency, newest in cell 0. An item is taken on
// start while busy is low; busy is then high for one cycle, and no item is taken
// until busy falls. The accepting edge registers the key match in every cell; in
// the busy cycle the hit entry, or the new one, enters cell 0 while the cells in
// front of it move one place down the chain, dropping the oldest entry on an
// eviction. A get answers with found and read_value, marked by done for one cycle
// in the cycle after busy; the receiver cannot stall and must take the word then.
// A put gives no word. No clearing pass is needed after reset.
module lru_key_value_cache #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            op,
    input  wire logic signed [lkvc_pkg::KEY_W-1:0] key,
    input  wire logic signed [lkvc_pkg::VAL_W-1:0] value,
    input  wire logic                            cfg_we,
    input  wire logic [lkvc_pkg::CAP_W-1:0]      capacity_in_use,
    output logic                                 done,
    output logic                                 found,
    output logic signed [lkvc_pkg::VAL_W-1:0]    read_value
);

    localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNTW = $clog2(ENTRIES + 1);
    localparam int CMPW = (CNTW > lkvc_pkg::CAP_W) ? CNTW : lkvc_pkg::CAP_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic                          state_reg;
    logic                          state_next;
    logic [lkvc_pkg::CAP_W-1:0]    cap_reg;
    logic [CNTW-1:0]               count_reg;
    logic [CNTW-1:0]               count_next;
    logic                          op_reg;
    logic [lkvc_pkg::KEY_W-1:0]    req_key_reg;
    logic [lkvc_pkg::VAL_W-1:0]    req_value_reg;
    logic                          done_reg;
    logic                          found_reg;
    logic [lkvc_pkg::VAL_W-1:0]    read_value_reg;

    logic                          accept;
    logic [CMPW-1:0]               cap_ext;
    logic [CMPW-1:0]               cap_eff;
    logic                          full;
    logic [CNTW-1:0]               tgt_wide;
    logic [IDXW-1:0]               tgt_index;
    lkvc_pkg::ctl_t                ctl;

    lkvc_pkg::entry_t              entry_chain [ENTRIES+1];
    logic                          sel_chain   [ENTRIES+1];
    lkvc_pkg::rd_t                 rd_chain    [ENTRIES+1];

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg == ST_UPD);

    // A capacity of zero acts as one, any capacity above the entry count as the entry count.
    assign cap_ext = CMPW'(cap_reg);
    assign cap_eff = (cap_ext == '0) ? CMPW'(1)
                   : ((cap_ext > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_ext);
    assign full    = CMPW'(count_reg) >= cap_eff;

    // Valid entries fill cells 0 to count-1, so the oldest sits at count-1.
    assign tgt_wide  = full ? (count_reg - CNTW'(1)) : count_reg;
    assign tgt_index = tgt_wide[IDXW-1:0];

    assign ctl.cmp_en  = accept;
    assign ctl.upd_en  = (state_reg == ST_UPD);
    assign ctl.any_hit = rd_chain[ENTRIES].found;
    assign ctl.move    = ctl.upd_en && ((op_reg == lkvc_pkg::OP_PUT) || ctl.any_hit);

    // The word entering cell 0: the new pair on a put, the hit pair on a get.
    assign entry_chain[0].valid = 1'b1;
    assign entry_chain[0].key   = req_key_reg;
    assign entry_chain[0].value = (op_reg == lkvc_pkg::OP_PUT) ? req_value_reg
                                                               : rd_chain[ENTRIES].value;
    assign sel_chain[ENTRIES]   = 1'b0;
    assign rd_chain[0]          = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lkvc_cell #(
            .IDX  (i),
            .IDXW (IDXW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .cmp_key    (key),
            .tgt_index  (tgt_index),
            .prev_entry (entry_chain[i]),
            .entry_out  (entry_chain[i+1]),
            .sel_in     (sel_chain[i+1]),
            .sel_out    (sel_chain[i]),
            .rd_in      (rd_chain[i]),
            .rd_out     (rd_chain[i+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.upd_en && (op_reg == lkvc_pkg::OP_PUT) && !ctl.any_hit && !full)
        begin
            count_next = count_reg + CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= lkvc_pkg::CAP_RESET;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= ctl.upd_en && (op_reg == lkvc_pkg::OP_GET);
            if (cfg_we)
            begin
                cap_reg <= capacity_in_use;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= op;
            req_key_reg   <= key;
            req_value_reg <= value;
        end
        if (ctl.upd_en)
        begin
            found_reg      <= ctl.any_hit;
            read_value_reg <= rd_chain[ENTRIES].value;
        end
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign read_value = read_value_reg;

endmodule

`default_nettype wire

@@ hdl/lkvc_checker.sv @@
// Port-level checker for the LRU key-value cache, bound to the top level.
`default_nettype none

`include "lru_key_value_cache_defines.svh"

module lkvc_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic                              busy,
    input  wire logic                              op,
    input  wire logic                              done,
    input  wire logic                              found,
    input  wire logic signed [lkvc_pkg::VAL_W-1:0] read_value
);

    // An accepted word holds the block for exactly one cycle.
    `LKVC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `LKVC_ASSERT_NEXT(a_busy_once, busy, !busy)

    // Every accepted get is answered with done, which is registered from the busy state.
    `LKVC_ASSERT_NOW(a_get_answers,
        $past(rst_n && start && !busy && (op == lkvc_pkg::OP_GET), 2) && $past(rst_n), done)

    // A miss reads as zero.
    `LKVC_ASSERT_NOW(a_miss_zero, done && !found, read_value == '0)

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .done       (done),
    .found      (found),
    .read_value (read_value)
);

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the LRU key-value cache: directed cases, then random traffic.
`default_nettype none

module tb;

    localparam int DEPTH       = lkvc_pkg::ENTRIES_DEF;
    localparam int CAP_BITS    = lkvc_pkg::CAP_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 4;

    typedef struct {
        logic                       hit;
        logic [lkvc_pkg::VAL_W-1:0] data;
    } lookup_answer_t;

    logic                              clk             = 1'b0;
    logic                              rst_n           = 1'b0;
    logic                              start           = 1'b0;
    logic                              op              = lkvc_pkg::OP_GET;
    logic signed [lkvc_pkg::KEY_W-1:0] key             = '0;
    logic signed [lkvc_pkg::VAL_W-1:0] value           = '0;
    logic                              cfg_we          = 1'b0;
    logic [lkvc_pkg::CAP_W-1:0]        capacity_in_use = lkvc_pkg::CAP_RESET;
    logic                              busy;
    logic                              done;
    logic                              found;
    logic signed [lkvc_pkg::VAL_W-1:0] read_value;

    // Shadow copy of the cache contents and the capacity register.
    bit                         slot_valid [DEPTH];
    logic [lkvc_pkg::KEY_W-1:0] slot_key   [DEPTH];
    logic [lkvc_pkg::VAL_W-1:0] slot_value [DEPTH];
    int                         slot_age   [DEPTH];
    int                         occupancy  = 0;
    logic [lkvc_pkg::CAP_W-1:0] cap_reg    = lkvc_pkg::CAP_RESET;

    lookup_answer_t lookup_answers[$];
    int             errors      = 0;
    int             cycles      = 0;
    bit             sender_gaps = 1'b0;

    lru_key_value_cache #(.ENTRIES(DEPTH)) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .key             (key),
        .value           (value),
        .cfg_we          (cfg_we),
        .capacity_in_use (capacity_in_use),
        .done            (done),
        .found           (found),
        .read_value      (read_value)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int usable_capacity(logic [lkvc_pkg::CAP_W-1:0] c);
        if (c == 0)
            return 1;
        if (c > DEPTH)
            return DEPTH;
        return int'(c);
    endfunction

    // Entries younger than slot s age by one, and s becomes the newest.
    function automatic void promote(int s);
        int r;
        r = slot_age[s];
        for (int i = 0; i < DEPTH; i++)
            if (slot_valid[i] && i != s && slot_age[i] < r)
                slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    function automatic void cache_access(logic o, logic [lkvc_pkg::KEY_W-1:0] k,
                                         logic [lkvc_pkg::VAL_W-1:0] v);
        int             hit_slot;
        int             victim;
        lookup_answer_t ans;
        hit_slot = -1;
        for (int i = 0; i < DEPTH; i++)
            if (hit_slot < 0 && slot_valid[i] && slot_key[i] == k)
                hit_slot = i;
        if (o == lkvc_pkg::OP_GET)
        begin
            ans.hit  = (hit_slot >= 0);
            ans.data = '0;
            if (hit_slot >= 0)
            begin
                ans.data = slot_value[hit_slot];
                promote(hit_slot);
            end
            lookup_answers.push_back(ans);
            return;
        end
        if (hit_slot >= 0)
        begin
            slot_value[hit_slot] = v;
            promote(hit_slot);
            return;
        end
        victim = -1;
        // Only one entry is dropped per insert, even when the capacity was lowered.
        if (occupancy >= usable_capacity(cap_reg))
        begin
            for (int i = 0; i < DEPTH; i++)
                if (slot_valid[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
                    victim = i;
            if (victim >= 0)
            begin
                slot_valid[victim] = 1'b0;
                occupancy--;
            end
        end
        if (victim < 0)
            for (int i = 0; i < DEPTH; i++)
                if (victim < 0 && !slot_valid[i])
                    victim = i;
        if (victim < 0)
            return;
        for (int i = 0; i < DEPTH; i++)
            if (slot_valid[i])
                slot_age[i]++;
        slot_valid[victim] = 1'b1;
        slot_key[victim]   = k;
        slot_value[victim] = v;
        slot_age[victim]   = 0;
        occupancy++;
    endfunction

    always @(posedge clk)
    begin
        lookup_answer_t want;
        if (rst_n && done)
        begin
            if (lookup_answers.size() == 0)
            begin
                $display("%0t: word with none expected, found %0b read_value %h",
                         $time, found, read_value);
                errors++;
            end
            else
            begin
                want = lookup_answers.pop_front();
                if (found !== want.hit)
                begin
                    $display("%0t: found expected %0b actual %0b", $time, want.hit, found);
                    errors++;
                end
                if (read_value !== want.data)
                begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.data, read_value);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic quiet(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Start stays high after acceptance so back-to-back words see no gap on start.
    task automatic send_word(logic o, logic [lkvc_pkg::KEY_W-1:0] k,
                             logic [lkvc_pkg::VAL_W-1:0] v);
        if (sender_gaps && $urandom_range(0, 7) == 0)
            quiet($urandom_range(1, 16));
        start <= 1'b1;
        op    <= o;
        key   <= k;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        cache_access(o, k, v);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (lookup_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_capacity(logic [lkvc_pkg::CAP_W-1:0] c);
        drain();
        cfg_we          <= 1'b1;
        capacity_in_use <= c;
        @(posedge clk);
        cap_reg = c;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_misses();
        send_word(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_word(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_put_get_extremes();
        send_word(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
        send_word(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_word(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(lkvc_pkg::OP_GET, 32'h8000_0001, 32'h0000_0000);
        send_word(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
        send_word(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    endtask

    // Capacity drops below the four entries already held.
    task automatic test_lowered_capacity();
        write_capacity(5'd2);
        send_word(lkvc_pkg::OP_PUT, 32'h0000_00A1, 32'hAAAA_0001);
        send_word(lkvc_pkg::OP_PUT, 32'h0000_00B2, 32'hBBBB_0002);
        send_word(lkvc_pkg::OP_GET, 32'h0000_00A1, 32'h0000_0000);
        send_word(lkvc_pkg::OP_PUT, 32'h0000_00C3, 32'hCCCC_0003);
        send_word(lkvc_pkg::OP_GET, 32'h0000_00B2, 32'h0000_0000);
        send_word(lkvc_pkg::OP_GET, 32'h0000_00A1, 32'h0000_0000);
        send_word(lkvc_pkg::OP_GET, 32'h0000_00C3, 32'h0000_0000);
    endtask

    // A capacity of zero behaves as one.
    task automatic test_zero_capacity();
        write_capacity(5'd0);
        send_word(lkvc_pkg::OP_PUT, 32'h5A5A_A5A5, 32'hDEAD_BEEF);
        send_word(lkvc_pkg::OP_GET, 32'h5A5A_A5A5, 32'h0000_0000);
        send_word(lkvc_pkg::OP_GET, 32'h0000_00C3, 32'h0000_0000);
    endtask

    task automatic test_random_traffic(int n_items, logic [lkvc_pkg::CAP_W-1:0] cap, bit gaps);
        logic [lkvc_pkg::KEY_W-1:0] pool[$];
        logic [lkvc_pkg::KEY_W-1:0] k;
        int                         pool_size;
        write_capacity(cap);
        sender_gaps = gaps;
        // A key pool a little larger than the capacity gives a mix of hits and evictions.
        pool_size = usable_capacity(cap) + $urandom_range(1, 6);
        repeat (pool_size) pool.push_back($urandom);
        repeat (n_items)
        begin
            if ($urandom_range(0, 9) == 0)
                k = $urandom;
            else
                k = pool[$urandom_range(0, pool_size - 1)];
            send_word(1'($urandom_range(0, 1)), k, $urandom);
            if ($urandom_range(0, 99) == 0)
                drain();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_misses();
        test_put_get_extremes();
        test_lowered_capacity();
        test_zero_capacity();
        test_random_traffic(100, 5'd31, 1'b1);
        test_random_traffic(100, 5'd16, 1'b1);
        test_random_traffic(100, 5'd1, 1'b1);
        test_random_traffic(100, 5'd0, 1'b0);
        test_random_traffic(100, CAP_BITS'($urandom_range(2, 15)), 1'b1);
        test_random_traffic(100, CAP_BITS'($urandom_range(0, 31)), 1'b1);
        test_random_traffic(100, 5'd8, 1'b1);
        test_random_traffic(100, 5'd16, 1'b0);
        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
